/* hw/rtl/cic_pkg.sv */
// ----------------------------------------------------------------------------
// cic_pkg
// types, codes and helpers shared by the compact integer codec pipeline
// ----------------------------------------------------------------------------
package cic_pkg;

    // command codes
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // integer size codes
    localparam logic [1:0] WC_2B  = 2'd0;
    localparam logic [1:0] WC_4B  = 2'd1;
    localparam logic [1:0] WC_8B  = 2'd2;
    localparam logic [1:0] WC_BAD = 2'd3;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_WIDTH = 3'd1,
        ST_TRUNC     = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_NONCANON  = 3'd4,
        ST_SIGN      = 3'd5
    } status_t;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  width_code;
        logic        signed_int;
        logic [63:0] data_in;
        logic [7:0]  prefix_in;
        logic [3:0]  bytes_available;
    } req_t;

    typedef struct packed {
        logic [7:0]  prefix_out;
        logic [63:0] data_out;
        logic [3:0]  length_out;
        status_t     status;
    } rsp_t;

    // first stage: width decode, fill flags, prefix fields
    typedef struct packed {
        logic        cmd;
        logic        bad;
        logic        sgn;
        logic [2:0]  bcb;
        logic [3:0]  nb;
        logic        zof;
        logic [63:0] data;
        logic [7:0]  nonfill;
        logic [3:0]  full;
        logic        trunc;
        logic        ovf;
        logic [7:0]  msb;
    } s1_t;

    // second stage: byte count, top payload byte, decoded value
    typedef struct packed {
        logic        cmd;
        logic        bad;
        logic        sgn;
        logic [2:0]  bcb;
        logic [3:0]  nb;
        logic        zof;
        logic [63:0] data;
        logic [3:0]  cnt;
        logic [7:0]  hb;
        logic        trunc;
        logic        ovf;
        logic [7:0]  msb;
    } s2_t;

    // ones in the low n bytes
    function automatic logic [63:0] bytes_mask(input logic [3:0] n);
        logic [63:0] m;
        for (int i = 0; i < 8; i++)
        begin
            m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

/* hw/rtl/cic_classify.sv */
// ----------------------------------------------------------------------------
// cic_classify
// first stage logic: size decode, sign fill, per-byte fill flags, prefix split
// ----------------------------------------------------------------------------
module cic_classify
    import cic_pkg::*;
#(
    parameter int unsigned MAX_BYTES = 8
)
(
    input  req_t req,
    output s1_t  s1
);

    logic [3:0]  nb;
    logic [2:0]  bcb;
    logic [63:0] v;
    logic        top;
    logic        ezof;
    logic        dsign;
    logic [3:0]  full;
    logic [7:0]  msb;

    always_comb
    begin
        nb  = 4'd2 << req.width_code;
        bcb = {1'b0, req.width_code} + 3'd2;
        v   = req.data_in & bytes_mask(nb);

        case (req.width_code)
            WC_2B:   top = v[15];
            WC_4B:   top = v[31];
            WC_8B:   top = v[63];
            default: top = 1'b0;
        endcase
        ezof = req.signed_int & top;

        // payload count sits in the low bcb bits of the prefix
        case (req.width_code)
            WC_2B:   full = {2'b00, req.prefix_in[1:0]};
            WC_4B:   full = {1'b0, req.prefix_in[2:0]};
            default: full = req.prefix_in[3:0];
        endcase

        dsign = req.signed_int & req.prefix_in[7];
        msb   = (req.prefix_in >> bcb) | (dsign ? (8'hFF << (4'd8 - {1'b0, bcb})) : 8'h00);

        s1.cmd = req.cmd;
        s1.bad = (req.width_code == WC_BAD) || (32'(nb) > MAX_BYTES);
        s1.sgn = req.signed_int;
        s1.bcb = bcb;
        s1.nb  = nb;
        s1.zof = (req.cmd == CMD_DECODE) ? dsign : ezof;
        s1.data = (req.cmd == CMD_DECODE) ? req.data_in : v;
        for (int i = 0; i < 8; i++)
        begin
            s1.nonfill[i] = (4'(i) < nb) && (v[8*i +: 8] != {8{ezof}});
        end
        s1.full  = full;
        s1.trunc = (full >= req.bytes_available) || (full > nb);
        s1.ovf   = (msb != {8{dsign}}) && (full >= nb);
        s1.msb   = msb;
    end

endmodule

/* hw/rtl/cic_finish.sv */
// ----------------------------------------------------------------------------
// cic_finish
// last stage logic: prefix fit test, encoder packing, decoder error checks
// ----------------------------------------------------------------------------
module cic_finish
    import cic_pkg::*;
(
    input  s2_t  s2,
    output rsp_t rsp
);

    logic [7:0] zb;
    logic [3:0] k;
    logic       fits;
    logic [3:0] ef;
    logic [7:0] emsb;

    always_comb
    begin
        zb   = {8{s2.zof}};
        // top byte fits above the count field (plus a sign bit when signed)
        k    = 4'd8 - {1'b0, s2.bcb} - {3'b000, s2.sgn};
        fits = (((s2.hb ^ zb) >> k) == 8'h00);

        ef   = (s2.cnt != 4'd0 && fits) ? s2.cnt - 4'd1 : s2.cnt;
        emsb = (s2.cnt != 4'd0 && fits) ? s2.hb : zb;

        rsp.prefix_out = 8'h00;
        rsp.data_out   = 64'h0;
        rsp.length_out = 4'd0;
        rsp.status     = ST_OK;

        if (s2.bad)
        begin
            rsp.status = ST_BAD_WIDTH;
        end
        else if (s2.cmd == CMD_ENCODE)
        begin
            rsp.prefix_out = {4'b0000, ef} | 8'(emsb << s2.bcb);
            rsp.data_out   = s2.data & bytes_mask(ef);
            rsp.length_out = ef + 4'd1;
        end
        else if (s2.trunc)
        begin
            rsp.status = ST_TRUNC;
        end
        else if (s2.ovf)
        begin
            rsp.status = ST_OVERFLOW;
        end
        else if (s2.msb == zb && s2.cnt != 4'd0 && fits)
        begin
            rsp.status = ST_NONCANON;
        end
        else if (s2.msb == zb && s2.cnt != 4'd0 && s2.sgn && s2.cnt == s2.nb &&
                 ((s2.msb ^ s2.hb) & 8'h80) != 8'h00)
        begin
            rsp.status = ST_SIGN;
        end
        else
        begin
            rsp.data_out   = s2.data;
            rsp.length_out = s2.cnt + 4'd1;
        end
    end

endmodule

/* hw/rtl/compact_integer_codec.sv */
// pipeline: three register stages, s1_reg, s2_reg and rsp_reg, ahead of rsp_valid
// throughput: one transaction per cycle unless stalled (fully pipelined datapath)
// stalls hold full stages in place; a bubble in the pipe is filled while rsp is stalled
// reset: rst_n asynchronous, active low, clears the stage valid bits only
// ----------------------------------------------------------------------------
// compact_integer_codec
// prefix varint encoder / decoder for 2, 4 and 8 byte integers
// ----------------------------------------------------------------------------
module compact_integer_codec
    import cic_pkg::*;
#(
    parameter int unsigned MAX_BYTES = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // stage registers, valid bits travel alongside
    s1_t  s1_reg;
    s1_t  s1_next;
    s2_t  s2_reg;
    s2_t  s2_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    // stage enables: a stage loads when it is empty or its content moves on
    logic en1;
    logic en2;
    logic en3;

    // stage B helpers
    logic [3:0]  ecnt;
    logic [3:0]  cnt;
    logic [2:0]  idx;
    logic [63:0] fill;
    logic [63:0] dval;

    assign en3       = !v3_reg || !rsp_stall;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign req_stall = !en1;
    assign rsp_valid = v3_reg;
    assign rsp       = rsp_reg;

    // stage A: width decode and byte classification
    cic_classify #(
        .MAX_BYTES (MAX_BYTES)
    ) u_classify (
        .req (req),
        .s1  (s1_next)
    );

    // stage B: leading fill byte scan, top payload byte pick, decoded value assembly
    always_comb
    begin
        // encoder keeps everything up to the highest byte that is not sign fill
        ecnt = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (s1_reg.nonfill[i])
            begin
                ecnt = 4'(i + 1);
            end
        end
        cnt = (s1_reg.cmd == CMD_DECODE) ? s1_reg.full : ecnt;
        idx = 3'(cnt - 4'd1);

        // decoder: payload bytes, prefix top bits above them, sign fill up to the width
        fill = s1_reg.zof ? (bytes_mask(s1_reg.nb) & ~bytes_mask(s1_reg.full)) : 64'h0;
        dval = (s1_reg.data & bytes_mask(s1_reg.full))
             | (fill & ~(64'hFF << {s1_reg.full, 3'b000}));
        if (s1_reg.full < s1_reg.nb)
        begin
            dval = dval | ({56'h0, s1_reg.msb} << {s1_reg.full, 3'b000});
        end

        s2_next.cmd   = s1_reg.cmd;
        s2_next.bad   = s1_reg.bad;
        s2_next.sgn   = s1_reg.sgn;
        s2_next.bcb   = s1_reg.bcb;
        s2_next.nb    = s1_reg.nb;
        s2_next.zof   = s1_reg.zof;
        s2_next.data  = (s1_reg.cmd == CMD_DECODE) ? dval : s1_reg.data;
        s2_next.cnt   = cnt;
        s2_next.hb    = s1_reg.data[{idx, 3'b000} +: 8];
        s2_next.trunc = s1_reg.trunc;
        s2_next.ovf   = s1_reg.ovf;
        s2_next.msb   = s1_reg.msb;
    end

    // stage C: prefix packing and error resolution
    cic_finish u_finish (
        .s2  (s2_reg),
        .rsp (rsp_next)
    );

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= req_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (en3)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef SYNTHESIS
    // any error result carries nothing but its status
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |->
            rsp.prefix_out == 8'h00 && rsp.data_out == 64'h0 && rsp.length_out == 4'd0)
        else $error("error transaction with nonzero payload");

    // a good transaction always reports a length of one to nine bytes
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_OK |-> rsp.length_out != 4'd0 && rsp.length_out <= 4'd9)
        else $error("length out of range");

    // the input only stalls when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> v1_reg && v2_reg && v3_reg && rsp_stall)
        else $error("input stalled with room in the pipe");

    // a held middle stage keeps its transaction
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !en2 |=> v2_reg && $stable(s2_reg))
        else $error("stage two lost a held transaction");
`endif

endmodule

/* tb/sv/compact_integer_codec_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compact_integer_codec_check
// watches both codec channels, predicts every result and compares it in order
// ----------------------------------------------------------------------------
module compact_integer_codec_check
    import cic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_t        req,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_t        rsp,
    output int unsigned fail_count,
    output int unsigned results_owed
);

    localparam int unsigned MAX_BYTES = 8;

    typedef struct {
        req_t txn;
        rsp_t want;
    } owed_result_t;

    owed_result_t owed_q[$];
    int unsigned  fails = 0;
    int unsigned  reported = 0;

    // all ones in the low n bytes
    function automatic logic [63:0] low_bytes(input int unsigned n);
        if (n >= 8)
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // index of the highest set bit plus one
    function automatic int unsigned bit_len(input logic [7:0] b);
        for (int j = 7; j >= 0; j--)
        begin
            if (b[j])
                return j + 1;
        end
        return 0;
    endfunction

    function automatic rsp_t predict_codec(input req_t r);
        rsp_t        o;
        int unsigned nb;
        int unsigned bcb;
        int unsigned full;
        int unsigned copied;
        int unsigned i;
        logic [7:0]  zof;
        logic [7:0]  msb;
        logic [7:0]  hb;
        logic [63:0] v;

        o = '0;
        o.status = ST_OK;
        if (r.width_code == WC_BAD)
        begin
            o.status = ST_BAD_WIDTH;
            return o;
        end
        nb = 2 << r.width_code;
        bcb = r.width_code + 2;
        if (nb > MAX_BYTES)
        begin
            o.status = ST_BAD_WIDTH;
            return o;
        end

        if (r.cmd == CMD_ENCODE)
        begin
            v = r.data_in & low_bytes(nb);
            zof = (r.signed_int && v[8 * nb - 1]) ? 8'hFF : 8'h00;
            full = nb;
            msb = zof;
            // strip sign-fill bytes from the top
            while (full != 0 && v[8 * (full - 1) +: 8] == zof)
                full--;
            // fold the top byte into the prefix when it fits beside count and sign
            if (full != 0)
            begin
                hb = v[8 * (full - 1) +: 8];
                if (bcb + bit_len(hb ^ zof) + r.signed_int <= 8)
                begin
                    full--;
                    msb = hb;
                end
            end
            o.prefix_out = 8'(full) | 8'(msb << bcb);
            o.data_out = v & low_bytes(full);
            o.length_out = 4'(full + 1);
            return o;
        end

        if (r.bytes_available == 4'd0)
        begin
            o.status = ST_TRUNC;
            return o;
        end
        full = r.prefix_in & ((1 << bcb) - 1);
        if (full + 1 > r.bytes_available || full > nb)
        begin
            o.status = ST_TRUNC;
            return o;
        end
        v = r.data_in & low_bytes(full);
        if (r.signed_int && r.prefix_in[7])
        begin
            msb = (r.prefix_in >> bcb) | (8'hFF << (8 - bcb));
            zof = 8'hFF;
        end
        else
        begin
            msb = r.prefix_in >> bcb;
            zof = 8'h00;
        end
        copied = full;
        if (msb != zof)
        begin
            if (copied >= nb)
            begin
                o.status = ST_OVERFLOW;
                return o;
            end
            v = v | (64'(msb) << (8 * copied));
            copied++;
        end
        else if (full != 0)
        begin
            hb = r.data_in[8 * (full - 1) +: 8];
            if (bit_len(hb ^ zof) + bcb + r.signed_int <= 8)
            begin
                o.status = ST_NONCANON;
                return o;
            end
            if (r.signed_int && full == nb && (msb[7] ^ hb[7]))
            begin
                o.status = ST_SIGN;
                return o;
            end
        end
        for (i = copied; i < nb; i++)
            v[8 * i +: 8] = zof;
        o.data_out = v;
        o.length_out = 4'(full + 1);
        return o;
    endfunction

    always @(posedge clk)
    begin : track
        owed_result_t entry;
        owed_result_t head;

        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                entry.txn = req;
                entry.want = predict_codec(req);
                owed_q.push_back(entry);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_q.size() == 0)
                begin
                    fails++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("codec: unexpected result prefix=%h data=%h len=%0d status=%0d",
                                 rsp.prefix_out, rsp.data_out, rsp.length_out, rsp.status);
                    end
                end
                else
                begin
                    head = owed_q.pop_front();
                    if (rsp.prefix_out !== head.want.prefix_out ||
                        rsp.data_out !== head.want.data_out ||
                        rsp.length_out !== head.want.length_out ||
                        rsp.status !== head.want.status)
                    begin
                        fails++;
                        if (reported < 10)
                        begin
                            reported++;
                            $write("codec mismatch: cmd=%0d wc=%0d sgn=%0d din=%h pfx=%h",
                                   head.txn.cmd, head.txn.width_code, head.txn.signed_int,
                                   head.txn.data_in, head.txn.prefix_in);
                            $write(" avail=%0d | expected prefix=%h data=%h len=%0d",
                                   head.txn.bytes_available, head.want.prefix_out,
                                   head.want.data_out, head.want.length_out);
                            $display(" status=%0d | got prefix=%h data=%h len=%0d status=%0d",
                                     head.want.status, rsp.prefix_out, rsp.data_out,
                                     rsp.length_out, rsp.status);
                        end
                    end
                end
            end
        end
        fail_count <= fails;
        results_owed <= owed_q.size();
    end

endmodule

/* tb/sv/compact_integer_codec_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compact_integer_codec_tb
// drives encode and decode transactions through the codec under varying
// backpressure; the checker beside the block predicts and compares results
// ----------------------------------------------------------------------------
module compact_integer_codec_tb;
    import cic_pkg::*;

    // random transactions per idling phase
    localparam int unsigned PHASE_ITEMS = 400;
    // length of the long receiver hold-off
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    // settle time after the last result
    localparam int unsigned DRAIN_CYCLES = 12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int unsigned fail_count;
    int unsigned results_owed;

    // idling odds in percent, changed per phase by the stimulus
    int unsigned send_idle_pct = 14;
    int unsigned recv_stall_pct = 57;
    // hold-offs asked by the stimulus, served by the receiver process
    int unsigned holds_asked = 0;

    compact_integer_codec #(
        .MAX_BYTES (8)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    compact_integer_codec_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly legal sizes, now and then the invalid one
    function automatic logic [1:0] rand_width();
        if ($urandom_range(15) == 0)
            return WC_BAD;
        case ($urandom_range(2))
            0: return WC_2B;
            1: return WC_4B;
            default: return WC_8B;
        endcase
    endfunction

    function automatic req_t make_req(input logic cmd, input logic [1:0] wc,
                                      input logic sgn, input logic [63:0] data,
                                      input logic [7:0] pfx, input logic [3:0] avail);
        req_t r;
        r.cmd = cmd;
        r.width_code = wc;
        r.signed_int = sgn;
        r.data_in = data;
        r.prefix_in = pfx;
        r.bytes_available = avail;
        return r;
    endfunction

    // present one transaction after a random gap and hold it until accepted
    task automatic offer(input req_t item);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // one idling phase of random traffic; a hold-off is asked at item hold_at
    task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                input int hold_at);
        int unsigned k;
        int unsigned pick;
        int unsigned nb;
        int unsigned bcb;
        int unsigned cnt;
        logic [1:0]  wc;
        logic        sgn;
        logic [7:0]  hi;
        logic [63:0] data;
        logic [3:0]  avail;

        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (k = 0; k < PHASE_ITEMS; k++)
        begin
            if (k == hold_at)
                holds_asked++;
            pick = $urandom_range(19);
            wc = rand_width();
            sgn = 1'($urandom_range(1));
            if (pick < 8)
            begin
                // encode: values with a random number of significant bits,
                // positive or negative, with junk above the integer width
                data = rand64() >> $urandom_range(63);
                if ($urandom_range(1))
                    data = ~data;
                offer(make_req(CMD_ENCODE, wc, sgn, data, 8'($urandom), 4'($urandom)));
            end
            else if (pick < 17)
            begin
                // decode: a prefix whose count mostly fits the width, high bits
                // either sign fill or random, matching availability mostly
                nb = (wc == WC_BAD) ? 8 : (2 << wc);
                bcb = (wc == WC_BAD) ? 4 : wc + 2;
                if ($urandom_range(9) == 0)
                    cnt = $urandom_range((1 << bcb) - 1);
                else
                    cnt = $urandom_range(nb);
                if ($urandom_range(2) == 0)
                    hi = (sgn && $urandom_range(1)) ? 8'hFF : 8'h00;
                else
                    hi = 8'($urandom);
                data = rand64();
                // a small top payload byte provokes the noncanonical check
                if (cnt != 0 && cnt <= 8 && $urandom_range(3) == 0)
                    data[8 * (cnt - 1) +: 8] = {8{hi[7] & sgn}} ^ 8'($urandom_range(15));
                if ($urandom_range(6) == 0)
                    avail = 4'($urandom);
                else
                    avail = 4'(cnt + 1);
                offer(make_req(CMD_DECODE, wc, sgn, data, 8'(hi << bcb) | 8'(cnt), avail));
            end
            else
            begin
                // noise: every field fully random
                offer(make_req(1'($urandom_range(1)), 2'($urandom_range(3)), sgn, rand64(),
                               8'($urandom), 4'($urandom)));
            end
        end
    endtask

    // receiver: random stalls, and a long hold-off whenever one is asked
    initial
    begin : receiver
        int unsigned holds_done;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done++;
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: size and sign extremes for encode
        offer(make_req(CMD_ENCODE, WC_2B, 1'b0, 64'h0, 8'h00, 4'd0));
        offer(make_req(CMD_ENCODE, WC_2B, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 4'd15));
        offer(make_req(CMD_ENCODE, WC_4B, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 4'd0));
        offer(make_req(CMD_ENCODE, WC_8B, 1'b1, 64'h8000_0000_0000_0000, 8'h00, 4'd0));
        offer(make_req(CMD_ENCODE, WC_8B, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00, 4'd0));
        offer(make_req(CMD_ENCODE, WC_8B, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 4'd0));
        // top byte small enough to ride in the prefix, and one that is not
        offer(make_req(CMD_ENCODE, WC_4B, 1'b0, 64'h5, 8'h00, 4'd0));
        offer(make_req(CMD_ENCODE, WC_4B, 1'b1, 64'h40, 8'h00, 4'd0));
        offer(make_req(CMD_ENCODE, WC_2B, 1'b1, 64'h8000, 8'h00, 4'd0));
        // invalid size in both directions
        offer(make_req(CMD_ENCODE, WC_BAD, 1'b0, 64'h1234, 8'h00, 4'd0));
        offer(make_req(CMD_DECODE, WC_BAD, 1'b1, 64'h1234, 8'h01, 4'd2));
        // decode: nothing available, truncated, too many payload bytes
        offer(make_req(CMD_DECODE, WC_4B, 1'b0, 64'h12, 8'h01, 4'd0));
        offer(make_req(CMD_DECODE, WC_4B, 1'b0, 64'h1234, 8'h02, 4'd2));
        offer(make_req(CMD_DECODE, WC_8B, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h0F, 4'd15));
        // prefix top bits on a payload that already fills the width
        offer(make_req(CMD_DECODE, WC_2B, 1'b0, 64'h1234, 8'h06, 4'd3));
        // top payload byte would have fit in the prefix
        offer(make_req(CMD_DECODE, WC_2B, 1'b0, 64'h05, 8'h01, 4'd2));
        offer(make_req(CMD_DECODE, WC_8B, 1'b1, 64'hFF00_0000_0000_0000, 8'hF8, 4'd9));
        // sign of the top payload byte disagrees with the prefix sign
        offer(make_req(CMD_DECODE, WC_2B, 1'b1, 64'h8012, 8'h02, 4'd3));
        offer(make_req(CMD_DECODE, WC_8B, 1'b1, 64'h7F00_0000_0000_0000, 8'hF8, 4'd9));
        // good decodes: negative with folded byte, oversized availability,
        // full width, value held in the prefix alone
        offer(make_req(CMD_DECODE, WC_8B, 1'b1, 64'h33, 8'hE1, 4'd2));
        offer(make_req(CMD_DECODE, WC_4B, 1'b0, 64'hABCD, 8'h02, 4'd12));
        offer(make_req(CMD_DECODE, WC_8B, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h08, 4'd9));
        offer(make_req(CMD_DECODE, WC_2B, 1'b0, 64'h0, 8'hFC, 4'd1));

        // sender idles little and receiver much, then the reverse, then no
        // idling at all; the last phase holds the receiver off so the pipe
        // fills and the input stalls
        random_phase(14, 57, 150);
        random_phase(57, 14, -1);
        random_phase(0, 0, 100);
        req_valid <= 1'b0;

        // let the owed count catch up with the last transaction, then drain
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && results_owed == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
